/* sv/dbrs_pkg.sv */
// Package for the deduplicating bounded request stack.
// Holds sizes, the key and result types shared by the store and the top level.
package dbrs_pkg;

  localparam int DEPTH      = 16;
  localparam int COORD_BITS = 20;
  localparam int LEVEL_W    = 5;
  localparam int CFG_W      = 5;
  localparam int OCC_W      = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] QLIMIT_RST = CFG_W'(16);
  localparam logic             REQ_PUSH   = 1'b0;
  localparam logic             REQ_POP    = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0]    level;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } key_t;

  typedef struct packed {
    logic             popped;
    key_t             key;
    logic             dup;
    logic             evicted;
    logic [OCC_W-1:0] occupancy;
  } res_t;

endpackage

/* sv/dbrs_store.sv */
// Key store of the request stack: parallel duplicate match, shift on eviction,
// push and pop at the newest end. Depends on dbrs_pkg.
module dbrs_store import dbrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic             req_type,
  input  key_t             key,
  input  logic [CFG_W-1:0] limit,
  output res_t             res
);

  key_t             store_r [DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_dec;
  logic [DEPTH-1:0] match;
  logic             found, over, do_shift, do_write;
  logic [IDX_W-1:0] wr_idx, top_idx;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < cnt_r) && (store_r[i] == key);
    end
  end

  assign found   = |match;
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign top_idx = cnt_dec[IDX_W-1:0];
  assign over    = (LIM_W'(cnt_r) >= LIM_W'(limit)) || (cnt_r == CNT_W'(DEPTH));

  always_comb begin
    do_shift      = 1'b0;
    do_write      = 1'b0;
    wr_idx        = cnt_r[IDX_W-1:0];
    cnt_nxt       = cnt_r;
    res           = '0;
    if (req_type == REQ_PUSH) begin
      if (found) begin
        res.dup = 1'b1;
      end else if (over) begin
        res.evicted = 1'b1;
        if (cnt_r != '0) begin
          do_shift = 1'b1;
          do_write = 1'b1;
          wr_idx   = top_idx;
        end
      end else begin
        do_write = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end else if (cnt_r != '0) begin
      res.popped = 1'b1;
      res.key    = store_r[top_idx];
      cnt_nxt    = cnt_dec;
    end
    res.occupancy = OCC_W'(cnt_nxt);
  end

  // each entry takes either the new key or its younger neighbour
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_write && (wr_idx == IDX_W'(i))) begin
          store_r[i] <= key;
        end else if (do_shift && (i < DEPTH - 1)) begin
          store_r[i] <= store_r[(i + 1) % DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/dedup_bounded_request_stack.sv */
// Deduplicating bounded request stack, top level: input register, key store, result register.
// An accepted transfer is held in the input register; its result and strobe come from the result register.
// Throughput: one item per cycle; busy stays low, the store compares all entries at once.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (synchronous, rst_n low) empties the store and sets queue_limit to 16.
// Depends on dbrs_pkg and dbrs_store.
module dedup_bounded_request_stack import dbrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [COORD_BITS-1:0] in_tile_x,
  input  logic [COORD_BITS-1:0] in_tile_y,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  output logic                  out_strobe,
  output logic                  out_popped,
  output logic [LEVEL_W-1:0]    out_level,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  out_was_duplicate,
  output logic                  out_evicted,
  output logic [OCC_W-1:0]      out_occupancy
);

  logic             vld_r;
  logic             req_r;
  key_t             key_r;
  logic [CFG_W-1:0] qlimit_r;
  res_t             res_nxt, res_r;
  logic             strobe_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlimit_r <= QLIMIT_RST;
    end else if (cfg_wr_en) begin
      qlimit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r       <= in_req_type;
      key_r.level <= in_level;
      key_r.x     <= in_tile_x;
      key_r.y     <= in_tile_y;
    end
  end

  dbrs_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (vld_r),
    .req_type (req_r),
    .key      (key_r),
    .limit    (qlimit_r),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_popped        = res_r.popped;
  assign out_level         = res_r.key.level;
  assign out_x             = res_r.key.x;
  assign out_y             = res_r.key.y;
  assign out_was_duplicate = res_r.dup;
  assign out_evicted       = res_r.evicted;
  assign out_occupancy     = res_r.occupancy;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> strobe_r)
    else $error("accepted item gave no result strobe");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (int'(out_occupancy) <= DEPTH))
    else $error("occupancy above store depth");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(out_popped && (out_was_duplicate || out_evicted)) &&
                 !(out_was_duplicate && out_evicted))
    else $error("conflicting result flags");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for dedup_bounded_request_stack: directed and random push/pop
// traffic under several queue_limit settings, checked against an in-bench stack predictor.
// Depends on dbrs_pkg and the dedup_bounded_request_stack RTL.
`timescale 1ns / 100ps

module testbench;
  import dbrs_pkg::*;

  localparam int POOL_N         = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_PHASES       = 11;

  typedef struct packed {
    logic req_type;
    key_t key;
  } req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_req_type = REQ_PUSH;
  logic [LEVEL_W-1:0]    in_level = '0;
  logic [COORD_BITS-1:0] in_tile_x = '0;
  logic [COORD_BITS-1:0] in_tile_y = '0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  out_strobe;
  logic                  out_popped;
  logic [LEVEL_W-1:0]    out_level;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_was_duplicate;
  logic                  out_evicted;
  logic [OCC_W-1:0]      out_occupancy;

  req_t pending_requests[$];
  res_t expected_results[$];
  key_t key_pool[POOL_N];

  // stack predictor state
  key_t             stack_keys[DEPTH];
  int               held_keys;
  logic [CFG_W-1:0] limit_model;

  logic took = 1'b0;
  int   stall_cycles = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   errors = 0;
  int   n_push = 0, n_pop = 0, n_dup = 0, n_evict = 0, n_empty_pop = 0, n_cfg = 0;

  dedup_bounded_request_stack dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_level          (in_level),
    .in_tile_x         (in_tile_x),
    .in_tile_y         (in_tile_y),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_strobe        (out_strobe),
    .out_popped        (out_popped),
    .out_level         (out_level),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_was_duplicate (out_was_duplicate),
    .out_evicted       (out_evicted),
    .out_occupancy     (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic apply_request(input req_t r, output res_t res);
    int   lim;
    int   i;
    logic found;
    res   = '0;
    found = 1'b0;
    lim   = (int'(limit_model) > DEPTH) ? DEPTH : int'(limit_model);
    if (r.req_type == REQ_PUSH) begin
      for (i = 0; i < held_keys; i++)
        if (stack_keys[i] == r.key) found = 1'b1;
      if (found) begin
        res.dup = 1'b1;
      end else if (held_keys + 1 > lim) begin
        res.evicted = 1'b1;
        if (held_keys > 0) begin
          for (i = 1; i < held_keys; i++) stack_keys[i-1] = stack_keys[i];
          stack_keys[held_keys-1] = r.key;
        end
      end else begin
        stack_keys[held_keys] = r.key;
        held_keys++;
      end
    end else if (held_keys > 0) begin
      held_keys--;
      res.popped = 1'b1;
      res.key    = stack_keys[held_keys];
    end
    res.occupancy = OCC_W'(held_keys);
  endtask

  // predictor and result checker
  always @(posedge clk) begin
    res_t want;
    req_t seen_req;
    if (!rst_n) begin
      held_keys   = 0;
      limit_model = QLIMIT_RST;
      took        = 1'b0;
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          flag_error("result strobe with no transfer outstanding");
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          compare_field("popped", 32'(out_popped), 32'(want.popped));
          compare_field("out_level", 32'(out_level), 32'(want.key.level));
          compare_field("out_x", 32'(out_x), 32'(want.key.x));
          compare_field("out_y", 32'(out_y), 32'(want.key.y));
          compare_field("was_duplicate", 32'(out_was_duplicate), 32'(want.dup));
          compare_field("evicted", 32'(out_evicted), 32'(want.evicted));
          compare_field("occupancy", 32'(out_occupancy), 32'(want.occupancy));
        end
      end
      if (cfg_wr_en) limit_model = cfg_wr_data;
      took = start && !busy;
      if (took) begin
        seen_req.req_type  = in_req_type;
        seen_req.key.level = in_level;
        seen_req.key.x     = in_tile_x;
        seen_req.key.y     = in_tile_y;
        apply_request(seen_req, want);
        expected_results.insert(expected_results.size(), want);
        if (seen_req.req_type == REQ_PUSH) n_push++;
        else n_pop++;
        if (want.dup) n_dup++;
        if (want.evicted) n_evict++;
        if (seen_req.req_type == REQ_POP && !want.popped) n_empty_pop++;
      end
    end
    stall_cycles = (took || out_strobe) ? 0 : stall_cycles + 1;
  end

  // driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    req_t nxt;
    logic go;
    if (took) pending_requests.delete(0);
    go            = 1'b0;
    nxt.req_type  = 1'($urandom_range(0, 1));
    nxt.key.level = LEVEL_W'($urandom);
    nxt.key.x     = COORD_BITS'($urandom);
    nxt.key.y     = COORD_BITS'($urandom);
    if (!rst_n) begin
      go = 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_requests.size() > 0) begin
      go  = 1'b1;
      nxt = pending_requests[0];
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    start       <= go;
    in_req_type <= nxt.req_type;
    in_level    <= nxt.key.level;
    in_tile_x   <= nxt.key.x;
    in_tile_y   <= nxt.key.y;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic add_req(input logic t, input logic [LEVEL_W-1:0] l,
                         input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    req_t r;
    r.req_type  = t;
    r.key.level = l;
    r.key.x     = x;
    r.key.y     = y;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7: k = key_pool[$urandom_range(0, POOL_N - 1)];
      8: k = '1;
      9: k = '0;
      default: begin
        k.level = LEVEL_W'($urandom);
        k.x     = COORD_BITS'($urandom);
        k.y     = COORD_BITS'($urandom);
      end
    endcase
    return k;
  endfunction

  task automatic add_random(input int n, input int push_pct);
    req_t r;
    repeat (n) begin
      r.req_type = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
      r.key      = pick_key();
      pending_requests.insert(pending_requests.size(), r);
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= CFG_W'($urandom);
    n_cfg++;
  endtask

  initial begin
    int limits[N_PHASES]   = '{16, 1, 5, 31, 0, 8, 2, 17, 3, 16, 12};
    int push_pct[N_PHASES] = '{75, 60, 65, 85, 60, 55, 60, 70, 40, 80, 45};
    int p;
    key_pool[0] = '1;
    key_pool[1] = '0;
    for (p = 2; p < POOL_N; p++) begin
      key_pool[p].level = LEVEL_W'($urandom);
      key_pool[p].x     = COORD_BITS'($urandom);
      key_pool[p].y     = COORD_BITS'($urandom);
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset limit: empty pop, extremes, duplicate, drain past empty
    add_req(REQ_POP, '1, '1, '1);
    add_req(REQ_PUSH, '0, '0, '0);
    add_req(REQ_PUSH, '1, '1, '1);
    add_req(REQ_PUSH, '0, '0, '0);
    add_req(REQ_POP, '0, '0, '0);
    add_req(REQ_POP, '0, '0, '0);
    add_req(REQ_POP, '0, '0, '0);
    // zero limit: the key just pushed is evicted
    set_limit(CFG_W'(0));
    add_req(REQ_PUSH, 5'd1, 20'd5, 20'd6);
    add_req(REQ_PUSH, 5'd1, 20'd5, 20'd6);
    // small limit: eviction, duplicate, re-push of an evicted key
    set_limit(CFG_W'(2));
    add_req(REQ_PUSH, 5'd1, 20'd5, 20'd6);
    add_req(REQ_PUSH, 5'd2, 20'd7, 20'd8);
    add_req(REQ_PUSH, 5'd3, 20'd9, 20'd10);
    add_req(REQ_PUSH, 5'd2, 20'd7, 20'd8);
    add_req(REQ_PUSH, 5'd1, 20'd5, 20'd6);
    add_req(REQ_POP, '0, '0, '0);
    // limit above depth saturates
    set_limit(CFG_W'(31));
    add_req(REQ_PUSH, 5'd4, 20'h80000, 20'h00001);
    add_req(REQ_PUSH, 5'd16, 20'h00001, 20'h80000);
    // limit lowered below occupancy
    set_limit(CFG_W'(1));
    add_req(REQ_PUSH, 5'd31, 20'h12345, 20'h54321);
    add_req(REQ_PUSH, 5'd4, 20'h80000, 20'h00001);

    for (p = 0; p < N_PHASES; p++) begin
      set_limit(CFG_W'(limits[p]));
      add_random(55, push_pct[p]);
    end

    wait_idle();
    while (expected_results.size() != 0) begin
      flag_error("expected result never arrived");
      expected_results.delete(0);
    end
    $display("Transfers: %0d pushes (%0d duplicates, %0d evictions), %0d pops (%0d empty)",
             n_push, n_dup, n_evict, n_pop, n_empty_pop);
    $display("queue_limit written %0d times; %0d mismatches", n_cfg, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
